// File: src/lmsd_pkg.sv
// shared types and codes for the led matrix scan driver
package lmsd_pkg;

    // input item kinds
    localparam logic [1:0] KIND_ROW   = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // result kinds
    localparam logic [1:0] OUT_DATA  = 2'd0;
    localparam logic [1:0] OUT_LATCH = 2'd1;
    localparam logic [1:0] OUT_OFF   = 2'd2;

    // brightness codes
    localparam logic [1:0] BRIGHT_LOW = 2'd0;
    localparam logic [1:0] BRIGHT_MED = 2'd1;

    // register indexes
    localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] REG_PERIOD     = 2'd1;
    localparam logic [1:0] REG_DATA_POL   = 2'd2;
    localparam logic [1:0] REG_OE_POL     = 2'd3;

    localparam int CHUNK_BITS = 8;
    localparam int ADDR_W     = 4;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    // ceil(2^18 / 5): exact quotient by five for any 16-bit value
    localparam logic [15:0] DIV5_RECIP = 16'hCCCD;
    localparam int          DIV5_SHIFT = 18;

    typedef struct packed {
        logic [1:0]  brightness;
        logic [15:0] period;
        logic        data_invert;
        logic        oe_high_lit;
    } lmsd_cfg_t;

    typedef struct packed {
        logic take;
        logic load_data;
        logic load_latch;
        logic load_off;
    } lmsd_cmd_t;

    typedef struct packed {
        logic tick_refresh;
        logic tick_off;
        logic last_byte;
    } lmsd_sts_t;

endpackage

// File: src/lmsd_ctrl.sv
// sequencing state machine and output valid for the scan driver
module lmsd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  lmsd_pkg::lmsd_sts_t sts,
    output lmsd_pkg::lmsd_cmd_t cmd
);
    import lmsd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DATA,
        ST_LATCH,
        ST_OFF
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (sts.tick_refresh)
                        state_next = ST_DATA;
                    else if (sts.tick_off)
                        state_next = ST_OFF;
                end
            end
            ST_DATA:
            begin
                if (slot_free)
                begin
                    cmd.load_data = 1'b1;
                    if (sts.last_byte)
                        state_next = ST_LATCH;
                end
            end
            ST_LATCH:
            begin
                if (slot_free)
                begin
                    cmd.load_latch = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_OFF:
            begin
                if (slot_free)
                begin
                    cmd.load_off = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.load_data || cmd.load_latch || cmd.load_off)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: src/lmsd_dp.sv
// frame store, scan counters, oe timing and output register
module lmsd_dp #(
    parameter int PANEL_WIDTH  = 32,
    parameter int PANEL_HEIGHT = 16,
    parameter int SCAN_LINES   = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lmsd_pkg::lmsd_cfg_t  cfg,
    input  lmsd_pkg::lmsd_cmd_t  cmd,
    output lmsd_pkg::lmsd_sts_t  sts,
    input  logic [1:0]           kind,
    input  logic [3:0]           row_index,
    input  logic [31:0]          row_bits,
    input  logic [4:0]           pixel_x,
    input  logic [3:0]           pixel_y,
    input  logic                 pixel_on,
    output logic [1:0]           out_kind,
    output logic [7:0]           data_pins,
    output logic [1:0]           row_addr,
    output logic                 oe_pin,
    output logic                 last
);
    import lmsd_pkg::*;

    localparam int ROWS_PER_LINE = PANEL_HEIGHT / SCAN_LINES;
    localparam int CHUNK_COUNT   = PANEL_WIDTH / CHUNK_BITS;
    localparam int ROW_W   = $clog2(PANEL_HEIGHT);
    localparam int COL_W   = $clog2(PANEL_WIDTH);
    localparam int SCAN_W  = (SCAN_LINES > 1) ? $clog2(SCAN_LINES) : 1;
    localparam int SUB_W   = (ROWS_PER_LINE > 1) ? $clog2(ROWS_PER_LINE) : 1;
    localparam int CHUNK_W = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;

    logic [PANEL_WIDTH-1:0] frame_reg [PANEL_HEIGHT];

    logic [SCAN_W-1:0]  scan_reg, scan_next;
    logic [15:0]        tick_reg, tick_next;
    logic [15:0]        cd_reg, cd_next;
    logic               pending_reg, pending_next;
    logic               oe_lit_reg, oe_lit_next;
    logic [SUB_W-1:0]   sub_reg, sub_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;

    logic [1:0] out_kind_reg;
    logic [7:0] data_reg;
    logic [1:0] addr_reg;
    logic       oe_reg;
    logic       last_reg;

    logic [ROW_W-1:0]       scan_row;
    logic [ROW_W-1:0]       rd_addr;
    logic [PANEL_WIDTH-1:0] rd_row;
    logic [7:0]             byte_bits;
    logic                   wr_en;
    logic [ROW_W-1:0]       wr_row;
    logic [PANEL_WIDTH-1:0] wr_data;
    logic [16:0]            tick_inc;
    logic [15:0]            cd_dec;
    logic                   is_tick;
    logic                   refresh;
    logic [31:0]            div5_prod;
    logic [15:0]            duty;
    logic                   dim;
    logic                   oe_level;

    // rows s+(k-1)*lines down to s for each chunk
    assign scan_row = ROW_W'(int'(sub_reg) * SCAN_LINES + int'(scan_reg));
    assign rd_addr  = cmd.take ? ROW_W'(pixel_y) : scan_row;
    assign rd_row   = frame_reg[rd_addr];
    assign byte_bits = rd_row[int'(chunk_reg) * CHUNK_BITS +: CHUNK_BITS]
                       ^ {8{cfg.data_invert}};

    assign tick_inc = {1'b0, tick_reg} + 17'd1;
    assign cd_dec   = cd_reg - 16'd1;
    assign is_tick  = (kind == KIND_TICK);
    assign refresh  = is_tick && (tick_inc >= {1'b0, cfg.period});

    assign sts.tick_refresh = refresh;
    assign sts.tick_off     = is_tick && !refresh && pending_reg && (cd_dec == 16'd0);
    assign sts.last_byte    = (sub_reg == '0) && (chunk_reg == CHUNK_W'(CHUNK_COUNT - 1));

    // duty length for the dimmed levels
    assign div5_prod = cfg.period * DIV5_RECIP;
    assign dim       = (cfg.brightness == BRIGHT_LOW) || (cfg.brightness == BRIGHT_MED);
    always_comb
    begin
        if (cfg.brightness == BRIGHT_LOW)
            duty = 16'(div5_prod >> DIV5_SHIFT);
        else
            duty = {1'b0, cfg.period[15:1]};
        if (duty == 16'd0)
            duty = 16'd1;
    end

    assign oe_level = oe_lit_reg ? cfg.oe_high_lit : !cfg.oe_high_lit;

    // frame writes
    always_comb
    begin
        wr_en   = 1'b0;
        wr_row  = ROW_W'(row_index);
        wr_data = PANEL_WIDTH'(row_bits);
        if (cmd.take)
        begin
            if (kind == KIND_ROW && int'(row_index) < PANEL_HEIGHT)
                wr_en = 1'b1;
            else if (kind == KIND_PIXEL && int'(pixel_x) < PANEL_WIDTH
                     && int'(pixel_y) < PANEL_HEIGHT)
            begin
                wr_en   = 1'b1;
                wr_row  = ROW_W'(pixel_y);
                wr_data = rd_row;
                wr_data[COL_W'(pixel_x)] = pixel_on;
            end
        end
    end

    always_comb
    begin
        scan_next    = scan_reg;
        tick_next    = tick_reg;
        cd_next      = cd_reg;
        pending_next = pending_reg;
        oe_lit_next  = oe_lit_reg;
        sub_next     = sub_reg;
        chunk_next   = chunk_reg;

        if (cmd.take && is_tick)
        begin
            if (refresh)
            begin
                tick_next  = 16'd0;
                sub_next   = SUB_W'(ROWS_PER_LINE - 1);
                chunk_next = '0;
            end
            else
            begin
                tick_next = tick_inc[15:0];
                if (pending_reg)
                begin
                    cd_next = cd_dec;
                    if (cd_dec == 16'd0)
                    begin
                        pending_next = 1'b0;
                        oe_lit_next  = 1'b0;
                    end
                end
            end
        end

        if (cmd.load_data)
        begin
            if (sub_reg == '0)
            begin
                sub_next   = SUB_W'(ROWS_PER_LINE - 1);
                chunk_next = chunk_reg + CHUNK_W'(1);
            end
            else
                sub_next = sub_reg - SUB_W'(1);
        end

        if (cmd.load_latch)
        begin
            oe_lit_next = 1'b1;
            if (int'(scan_reg) == SCAN_LINES - 1)
                scan_next = '0;
            else
                scan_next = scan_reg + SCAN_W'(1);
            if (dim && duty < cfg.period)
            begin
                cd_next      = duty;
                pending_next = 1'b1;
            end
            else
            begin
                cd_next      = 16'd0;
                pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PANEL_HEIGHT; i++)
                frame_reg[i] <= '0;
            scan_reg    <= '0;
            tick_reg    <= 16'd0;
            cd_reg      <= 16'd0;
            pending_reg <= 1'b0;
            oe_lit_reg  <= 1'b1;
            sub_reg     <= '0;
            chunk_reg   <= '0;
        end
        else
        begin
            if (wr_en)
                frame_reg[wr_row] <= wr_data;
            scan_reg    <= scan_next;
            tick_reg    <= tick_next;
            cd_reg      <= cd_next;
            pending_reg <= pending_next;
            oe_lit_reg  <= oe_lit_next;
            sub_reg     <= sub_next;
            chunk_reg   <= chunk_next;
        end
    end

    // output register, payload only
    always_ff @(posedge clk)
    begin
        if (cmd.load_data)
        begin
            out_kind_reg <= OUT_DATA;
            data_reg     <= byte_bits;
            addr_reg     <= 2'd0;
            oe_reg       <= oe_level;
            last_reg     <= 1'b0;
        end
        else if (cmd.load_latch)
        begin
            out_kind_reg <= OUT_LATCH;
            data_reg     <= 8'd0;
            addr_reg     <= 2'(scan_reg);
            oe_reg       <= cfg.oe_high_lit;
            last_reg     <= 1'b1;
        end
        else if (cmd.load_off)
        begin
            out_kind_reg <= OUT_OFF;
            data_reg     <= 8'd0;
            addr_reg     <= 2'd0;
            oe_reg       <= oe_level;
            last_reg     <= 1'b1;
        end
    end

    assign out_kind  = out_kind_reg;
    assign data_pins = data_reg;
    assign row_addr  = addr_reg;
    assign oe_pin    = oe_reg;
    assign last      = last_reg;

endmodule

// File: src/led_matrix_scan_driver.sv
// top level of the led matrix scan driver: config registers, controller and datapath
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser kind, tdata write fields
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser out_kind, tdata pins, tlast
//  apb       in   psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// a row write, pixel write or quiet tick is taken in idle and leaves the controller idle
// an oe-off tick goes to the off state, which loads its result once the output slot is free
// a refresh tick loads PANEL_WIDTH/8 * PANEL_HEIGHT/SCAN_LINES data bytes, then a latch:
// one frame row byte is read and loaded into the output register each cycle the slot is free
// reset clears the frame store at once, no clearing pass
// m_axis_tready low holds the result; writes and ticks are still taken while the controller is idle
module led_matrix_scan_driver #(
    parameter int PANEL_WIDTH  = 32,
    parameter int PANEL_HEIGHT = 16,
    parameter int SCAN_LINES   = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // row_index[3:0], row_bits[35:4], pixel_x[40:36], pixel_y[44:41], pixel_on[45], zero pad
    input  logic [lmsd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // data_pins[7:0], row_addr[9:8], oe_pin[10], zero pad
    output logic [lmsd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // out_kind[1:0]
    output logic [1:0]                      m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lmsd_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import lmsd_pkg::*;

    logic [1:0]  brightness_reg;
    logic [15:0] period_reg;
    logic        data_pol_reg;
    logic        oe_pol_reg;
    logic        cfg_wr;
    logic [1:0]  reg_sel;

    lmsd_cfg_t cfg;
    lmsd_cmd_t cmd;
    lmsd_sts_t sts;

    logic [1:0] out_kind;
    logic [7:0] data_pins;
    logic [1:0] row_addr;
    logic       oe_pin;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= 2'd2;
            period_reg     <= 16'd500;
            data_pol_reg   <= 1'b1;
            oe_pol_reg     <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_BRIGHTNESS: brightness_reg <= pwdata[1:0];
                REG_PERIOD:     period_reg     <= pwdata[15:0];
                REG_DATA_POL:   data_pol_reg   <= pwdata[0];
                REG_OE_POL:     oe_pol_reg     <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_BRIGHTNESS: prdata = {30'd0, brightness_reg};
            REG_PERIOD:     prdata = {16'd0, period_reg};
            REG_DATA_POL:   prdata = {31'd0, data_pol_reg};
            REG_OE_POL:     prdata = {31'd0, oe_pol_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg.brightness  = brightness_reg;
    assign cfg.period      = period_reg;
    assign cfg.data_invert = data_pol_reg;
    assign cfg.oe_high_lit = oe_pol_reg;

    lmsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lmsd_dp #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .SCAN_LINES   (SCAN_LINES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .sts       (sts),
        .kind      (s_axis_tuser),
        .row_index (s_axis_tdata[3:0]),
        .row_bits  (s_axis_tdata[35:4]),
        .pixel_x   (s_axis_tdata[40:36]),
        .pixel_y   (s_axis_tdata[44:41]),
        .pixel_on  (s_axis_tdata[45]),
        .out_kind  (out_kind),
        .data_pins (data_pins),
        .row_addr  (row_addr),
        .oe_pin    (oe_pin),
        .last      (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = {5'd0, oe_pin, row_addr, data_pins};

    // a latch closes the request's results and lights the panel
    a_latch_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == OUT_LATCH |-> m_axis_tlast)
        else $error("latch result not marked last");

    a_latch_lit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == OUT_LATCH |-> m_axis_tdata[10] == oe_pol_reg)
        else $error("latch result with oe not lit");

    a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == OUT_OFF |-> m_axis_tdata[10] != oe_pol_reg)
        else $error("oe-off result with oe lit");

    a_data_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == OUT_DATA |-> !m_axis_tlast)
        else $error("data byte marked last");

endmodule

// File: verif/tb_led_matrix_scan_driver.sv
// self-checking testbench for the led matrix scan driver, predicted pin sequence against the stream output
module tb_led_matrix_scan_driver;
    import lmsd_pkg::*;

    localparam logic [1:0] KIND_SPARE  = 2'd3;
    localparam logic [1:0] BRIGHT_HIGH = 2'd2;
    localparam logic [1:0] BRIGHT_ALT  = 2'd3;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 30;
    localparam int QUIET_RUN     = 40;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  row_index;
        logic [31:0] row_bits;
        logic [4:0]  px;
        logic [3:0]  py;
        logic        pon;
    } panel_req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] pins;
        logic [1:0] addr;
        logic       oe;
        logic       last;
    } pin_event_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = KIND_ROW;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [ADDR_W-1:0]     paddr         = '0;
    logic [31:0]           pwdata        = '0;
    logic [31:0]           prdata;
    logic                  pready;

    led_matrix_scan_driver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // panel model state and its copy of the registers
    logic [31:0] frame_rows [16];
    logic [1:0]  scan_line;
    logic [15:0] tick_cnt;
    logic [15:0] off_cnt;
    logic        off_armed;
    logic        oe_lit;
    logic [1:0]  cfg_bright;
    logic [15:0] cfg_period;
    logic        cfg_dpol;
    logic        cfg_oepol;

    panel_req_t  feed_q [$];
    pin_event_t  due_events [$];
    panel_req_t  cur_req;
    pin_event_t  want_ev;
    pin_event_t  got_ev;
    int unsigned faults    = 0;
    int unsigned tx_gap    = 0;
    int unsigned tx_quiet  = 0;
    int unsigned rx_gap    = 0;
    int unsigned rx_quiet  = 0;
    int unsigned rx_next   = 0;
    int unsigned hold_left = 0;
    logic        hold_req  = 1'b0;
    logic        hold_seen = 1'b0;

    function automatic logic oe_level();
        return oe_lit ? cfg_oepol : ~cfg_oepol;
    endfunction

    function automatic void push_event(logic [1:0] k, logic [7:0] pins, logic [1:0] addr,
                                       logic fin);
        pin_event_t ev;
        ev.kind = k;
        ev.pins = pins;
        ev.addr = addr;
        ev.oe   = oe_level();
        ev.last = fin;
        due_events.push_back(ev);
    endfunction

    function automatic void scan_refresh();
        logic [3:0]  row;
        logic [7:0]  bits;
        logic [15:0] duty;
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            // rows of this scan line, bottom quarter first
            for (int sub = 3; sub >= 0; sub--)
            begin
                row  = {2'(sub), scan_line};
                bits = frame_rows[row][chunk*CHUNK_BITS +: CHUNK_BITS];
                if (cfg_dpol)
                    bits = ~bits;
                push_event(OUT_DATA, bits, 2'd0, 1'b0);
            end
        end
        oe_lit = 1'b1;
        push_event(OUT_LATCH, 8'd0, scan_line, 1'b1);
        scan_line = scan_line + 2'd1;
        off_armed = 1'b0;
        off_cnt   = '0;
        if (cfg_bright == BRIGHT_LOW || cfg_bright == BRIGHT_MED)
        begin
            duty = (cfg_bright == BRIGHT_LOW) ? cfg_period / 16'd5 : cfg_period / 16'd2;
            if (duty == 0)
                duty = 16'd1;
            if (duty < cfg_period)
            begin
                off_cnt   = duty;
                off_armed = 1'b1;
            end
        end
    endfunction

    function automatic void panel_apply(panel_req_t r);
        logic [16:0] next;
        case (r.kind)
            KIND_ROW:   frame_rows[r.row_index] = r.row_bits;
            KIND_PIXEL: frame_rows[r.py][r.px] = r.pon;
            KIND_TICK:
            begin
                next = {1'b0, tick_cnt} + 17'd1;
                if (next >= {1'b0, cfg_period})
                begin
                    tick_cnt = '0;
                    scan_refresh();
                end
                else
                begin
                    tick_cnt = next[15:0];
                    if (off_armed)
                    begin
                        off_cnt = off_cnt - 16'd1;
                        if (off_cnt == 0)
                        begin
                            off_armed = 1'b0;
                            oe_lit    = 1'b0;
                            push_event(OUT_OFF, 8'd0, 2'd0, 1'b1);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void reset_model();
        foreach (frame_rows[i])
            frame_rows[i] = '0;
        scan_line  = '0;
        tick_cnt   = '0;
        off_cnt    = '0;
        off_armed  = 1'b0;
        oe_lit     = 1'b1;
        cfg_bright = BRIGHT_HIGH;
        cfg_period = 16'd500;
        cfg_dpol   = 1'b1;
        cfg_oepol  = 1'b1;
    endfunction

    function automatic panel_req_t mk_req(logic [1:0] k, logic [3:0] idx, logic [31:0] bits,
                                          logic [4:0] x, logic [3:0] y, logic on);
        panel_req_t r;
        r.kind      = k;
        r.row_index = idx;
        r.row_bits  = bits;
        r.px        = x;
        r.py        = y;
        r.pon       = on;
        return r;
    endfunction

    // mostly ticks so that scans come often, with frame writes mixed in
    function automatic panel_req_t rand_req();
        int unsigned pick;
        logic [1:0]  k;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            k = KIND_TICK;
        else if (pick < 78)
            k = KIND_ROW;
        else if (pick < 95)
            k = KIND_PIXEL;
        else
            k = KIND_SPARE;
        return mk_req(k, 4'($urandom), $urandom, 5'($urandom), 4'($urandom), 1'($urandom));
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void note_fault(string what, pin_event_t want, pin_event_t got);
        faults++;
        if (faults <= 10)
        begin
            $display("%s: got kind=%0d pins=%02h addr=%0d oe=%0d last=%0d",
                     what, got.kind, got.pins, got.addr, got.oe, got.last);
            $display("    want kind=%0d pins=%02h addr=%0d oe=%0d last=%0d",
                     want.kind, want.pins, want.addr, want.oe, want.last);
        end
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                panel_apply(cur_req);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap        <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (feed_q.size() != 0)
                begin
                    cur_req = feed_q.pop_front();
                    s_axis_tdata  <= {2'b00, cur_req.pon, cur_req.py, cur_req.px,
                                      cur_req.row_bits, cur_req.row_index};
                    s_axis_tuser  <= cur_req.kind;
                    s_axis_tvalid <= 1'b1;
                    if (tx_quiet != 0)
                    begin
                        tx_quiet <= tx_quiet - 1;
                        tx_gap   <= 0;
                    end
                    else
                    begin
                        tx_gap <= pick_gap();
                        if ($urandom_range(0, 24) == 0)
                            tx_quiet <= QUIET_RUN;
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // result monitor and ready generation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_next = rx_gap;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_ev.kind = m_axis_tuser;
                got_ev.pins = m_axis_tdata[7:0];
                got_ev.addr = m_axis_tdata[9:8];
                got_ev.oe   = m_axis_tdata[10];
                got_ev.last = m_axis_tlast;
                if (due_events.size() == 0)
                    note_fault("unexpected result", '0, got_ev);
                else
                begin
                    want_ev = due_events.pop_front();
                    if (got_ev !== want_ev)
                        note_fault("result mismatch", want_ev, got_ev);
                end
                if (rx_quiet != 0)
                begin
                    rx_quiet <= rx_quiet - 1;
                    rx_next = 0;
                end
                else
                begin
                    rx_next = pick_gap();
                    if ($urandom_range(0, 24) == 0)
                        rx_quiet <= QUIET_RUN;
                end
            end
            else if (rx_next != 0)
                rx_next = rx_next - 1;
            rx_gap        <= rx_next;
            m_axis_tready <= (rx_next == 0) && (hold_left == 0);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BRIGHTNESS: cfg_bright = value[1:0];
            REG_PERIOD:     cfg_period = value[15:0];
            REG_DATA_POL:   cfg_dpol   = value[0];
            REG_OE_POL:     cfg_oepol  = value[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_config(input logic [1:0] bright, input logic [15:0] period,
                              input logic dpol, input logic oepol);
        write_reg(REG_BRIGHTNESS, {30'd0, bright});
        write_reg(REG_PERIOD, {16'd0, period});
        write_reg(REG_DATA_POL, {31'd0, dpol});
        write_reg(REG_OE_POL, {31'd0, oepol});
    endtask

    // sender stops until every predicted result is back and the block has gone quiet
    task automatic drain();
        do
            @(negedge clk);
        while (feed_q.size() != 0 || s_axis_tvalid || due_events.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic random_burst(input int count);
        for (int i = 0; i < count; i++)
            feed_q.push_back(rand_req());
        drain();
    endtask

    initial
    begin
        reset_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // brightness three, zero period: every tick scans, both polarities plain
        set_config(BRIGHT_ALT, 16'd0, 1'b0, 1'b0);
        feed_q.push_back(mk_req(KIND_ROW, 4'd0, 32'hFFFF_FFFF, 5'd0, 4'd0, 1'b0));
        feed_q.push_back(mk_req(KIND_ROW, 4'd15, 32'hA5C3_0F81, 5'd0, 4'd0, 1'b0));
        feed_q.push_back(mk_req(KIND_ROW, 4'd12, 32'h8000_0001, 5'd0, 4'd0, 1'b0));
        feed_q.push_back(mk_req(KIND_ROW, 4'd4, 32'h0000_0000, 5'd0, 4'd0, 1'b0));
        feed_q.push_back(mk_req(KIND_PIXEL, 4'd0, 32'd0, 5'd31, 4'd15, 1'b1));
        feed_q.push_back(mk_req(KIND_PIXEL, 4'd0, 32'd0, 5'd0, 4'd0, 1'b0));
        feed_q.push_back(mk_req(KIND_PIXEL, 4'd0, 32'd0, 5'd0, 4'd3, 1'b1));
        feed_q.push_back(mk_req(KIND_SPARE, 4'hF, 32'hFFFF_FFFF, 5'h1F, 4'hF, 1'b1));
        repeat (4) feed_q.push_back(mk_req(KIND_TICK, 4'd0, 32'd0, 5'd0, 4'd0, 1'b0));
        drain();

        // duty of zero ticks stretched to one, oe turns off between scans
        set_config(BRIGHT_LOW, 16'd2, 1'b1, 1'b1);
        repeat (5) feed_q.push_back(mk_req(KIND_TICK, 4'd0, 32'd0, 5'd0, 4'd0, 1'b0));
        drain();

        // shortened period forces a scan while an oe-off is still counting
        set_config(BRIGHT_MED, 16'd6, 1'b0, 1'b0);
        repeat (7) feed_q.push_back(mk_req(KIND_TICK, 4'd0, 32'd0, 5'd0, 4'd0, 1'b0));
        drain();
        write_reg(REG_PERIOD, 32'd1);
        feed_q.push_back(mk_req(KIND_TICK, 4'd0, 32'd0, 5'd0, 4'd0, 1'b0));
        drain();

        set_config(BRIGHT_LOW, 16'd5, 1'b1, 1'b1);
        random_burst(60);

        // receiver backs off for a long stretch while requests keep coming
        set_config(BRIGHT_MED, 16'd7, 1'b0, 1'b0);
        hold_req <= ~hold_req;
        random_burst(60);

        set_config(BRIGHT_HIGH, 16'd9, 1'b1, 1'b0);
        random_burst(60);

        set_config(BRIGHT_MED, 16'd65535, 1'b0, 1'b1);
        random_burst(25);

        for (int ph = 0; ph < 4; ph++)
        begin
            set_config(2'($urandom_range(0, 3)), 16'($urandom_range(5, 16)),
                       1'($urandom), 1'($urandom));
            random_burst(45);
        end

        if (faults == 0 && due_events.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
